// ----- rtl/core/sha256_pkg.sv -----
// sha-256 package: round constants, initial hash, state encoding
// used by sha256_message_hash and sha256_round
`default_nettype none
package sha256_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t h;
		case (idx)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
endpackage
`default_nettype wire

// ----- rtl/core/sha256_if.sv -----
// valid/ready stream interfaces for the byte input and the digest output
// depends on nothing
`default_nettype none
interface sha256_byte_if;
	logic valid;
	logic ready;
	logic [7:0] msg_byte;
	logic final_byte;
	modport source (output valid, msg_byte, final_byte, input ready);
	modport sink (input valid, msg_byte, final_byte, output ready);
endinterface

interface sha256_digest_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sha256_message_hash.sv -----
// sha-256 top level: byte packer, padding sequencer, round loop, digest output
// depends on sha256_pkg, sha256_if, sha256_round
//
// channel   dir  payload                              beat
// in        in   msg_byte[7:0], final_byte            one message byte
// out       out  digest_word[31:0], word_index, last  one digest word
//
// a byte that completes no block is only packed; a full block adds a load step,
// 64 rounds and a fold step, all through the single round unit.
// after a final byte, padding runs one byte per cycle plus one or two blocks,
// then eight digest beats go out; out.ready stalls only the emit phase.
// reset loads the initial hash; no clearing pass.
`default_nettype none
module sha256_message_hash (
	input wire logic clk,
	input wire logic arst_n,
	sha256_byte_if.sink     in,
	sha256_digest_if.source out
);
	sha256_pkg::state_t state_q, state_d;
	sha256_pkg::word_t hash_q [8];
	sha256_pkg::word_t work_q [8];
	sha256_pkg::word_t win_q [16];
	sha256_pkg::word_t packer_q;
	logic [60:0] total_q;
	logic [6:0]  rnd_q;
	logic [1:0]  pad_q;     // 1 fill, 2 length
	logic        fin_q;     // 0x80 byte still owed, or padding done and digest due
	logic [2:0]  emit_q;
	logic [5:0]  pad_pos_q; // block position while padding
	logic [5:0]  pos;
	logic [7:0]  pad_byte;
	logic [63:0] bits;
	logic        take;
	sha256_pkg::word_t wnew;
	sha256_pkg::word_t next [8];

	assign pos = (state_q == sha256_pkg::ST_PAD) ? pad_pos_q : total_q[5:0];
	assign bits = {total_q, 3'b000};
	assign take = in.valid && in.ready;

	sha256_round u_round (
		.work(work_q),
		.w2(win_q[4'(rnd_q[3:0] - 4'd2)]),
		.w7(win_q[4'(rnd_q[3:0] - 4'd7)]),
		.w15(win_q[4'(rnd_q[3:0] - 4'd15)]),
		.w16(win_q[rnd_q[3:0]]),
		.wcur(win_q[rnd_q[3:0]]),
		.use_sched(rnd_q[5:4] != 2'd0),
		.rnd(rnd_q[5:0]),
		.wnew(wnew),
		.next(next)
	);

	// padding byte at current position: 0x80 mark, zero fill, then big-endian length
	always_comb begin
		if (pad_q == 2'd2)
			pad_byte = bits[{3'd7 - pos[2:0], 3'b000} +: 8];
		else if (pad_q == 2'd1 && !fin_q)
			pad_byte = 8'h00;
		else
			pad_byte = sha256_pkg::PAD_MARK;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (take && pos == 6'd63)
					state_d = sha256_pkg::ST_LOAD;
				else if (take && in.final_byte)
					state_d = sha256_pkg::ST_PAD;
			end
			sha256_pkg::ST_PAD: begin
				if (pos[5:0] == 6'd63 || (pad_q == 2'd2 && pos[2:0] == 3'd7))
					state_d = sha256_pkg::ST_LOAD;
			end
			sha256_pkg::ST_LOAD: state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_ROUND: begin
				if (rnd_q == 7'd63)
					state_d = sha256_pkg::ST_FOLD;
			end
			sha256_pkg::ST_FOLD: begin
				if (pad_q == 2'd0 && !fin_q)
					state_d = sha256_pkg::ST_IDLE;
				else if (pad_q == 2'd0)
					state_d = sha256_pkg::ST_EMIT;
				else
					state_d = sha256_pkg::ST_PAD;
			end
			sha256_pkg::ST_EMIT: begin
				if (out.ready && emit_q == 3'd7)
					state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in.ready = (state_q == sha256_pkg::ST_IDLE);
		out.valid = (state_q == sha256_pkg::ST_EMIT);
		out.digest_word = hash_q[emit_q];
		out.word_index = emit_q;
		out.last_word = (emit_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			for (int i = 0; i < 8; i++)
				hash_q[i] <= sha256_pkg::init_hash(3'(i));
			packer_q <= '0;
			total_q <= '0;
			rnd_q <= '0;
			pad_q <= '0;
			fin_q <= 1'b0;
			emit_q <= '0;
			pad_pos_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (take) begin
						packer_q <= {packer_q[23:0], in.msg_byte};
						if (pos[1:0] == 2'd3)
							win_q[pos[5:2]] <= {packer_q[23:0], in.msg_byte};
						total_q <= total_q + 61'd1;
						if (in.final_byte) begin
							fin_q <= 1'b1;
							pad_q <= 2'd1;
							pad_pos_q <= pos + 6'd1;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					// fin_q marks the 0x80 byte still owed
					packer_q <= {packer_q[23:0], pad_byte};
					if (pos[1:0] == 2'd3)
						win_q[pos[5:2]] <= {packer_q[23:0], pad_byte};
					if (pad_q == 2'd1 && fin_q)
						fin_q <= 1'b0;
					if (pad_q == 2'd2) begin
						if (pos[2:0] == 3'd7) begin
							pad_q <= 2'd0;
							fin_q <= 1'b1;
						end
					end else if (6'(pos + 6'd1) == sha256_pkg::LEN_POS)
						pad_q <= 2'd2;
					// position walks apart from the byte count, which feeds the length
					pad_pos_q <= pos + 6'd1;
				end
				sha256_pkg::ST_LOAD: begin
					work_q <= hash_q;
					rnd_q <= '0;
				end
				sha256_pkg::ST_ROUND: begin
					work_q <= next;
					if (rnd_q[5:4] != 2'd0)
						win_q[rnd_q[3:0]] <= wnew;
					rnd_q <= rnd_q + 7'd1;
				end
				sha256_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++)
						hash_q[i] <= hash_q[i] + work_q[i];
					rnd_q <= '0;
					emit_q <= '0;
				end
				sha256_pkg::ST_EMIT: begin
					if (out.ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								hash_q[i] <= sha256_pkg::init_hash(3'(i));
							total_q <= '0;
							packer_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/sha256_round.sv -----
// one sha-256 round and one schedule update, shared across all 64 rounds
// depends on sha256_pkg
`default_nettype none
module sha256_round (
	input  wire sha256_pkg::word_t work [8],
	input  wire sha256_pkg::word_t w2,
	input  wire sha256_pkg::word_t w7,
	input  wire sha256_pkg::word_t w15,
	input  wire sha256_pkg::word_t w16,
	input  wire sha256_pkg::word_t wcur,
	input  wire logic              use_sched,
	input  wire logic [5:0]        rnd,
	output sha256_pkg::word_t      wnew,
	output sha256_pkg::word_t      next [8]
);
	sha256_pkg::word_t s0, s1, w, t1, t2, e, a;

	always_comb begin
		s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		wnew = s1 + w7 + s0 + w16;
		w = use_sched ? wnew : wcur;
		e = work[4];
		a = work[0];
		t1 = work[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & work[5]) ^ (~e & work[6])) + sha256_pkg::round_k(rnd) + w;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & work[1]) ^ (a & work[2]) ^ (work[1] & work[2]));
		next[7] = work[6];
		next[6] = work[5];
		next[5] = work[4];
		next[4] = work[3] + t1;
		next[3] = work[2];
		next[2] = work[1];
		next[1] = work[0];
		next[0] = t1 + t2;
	end
endmodule
`default_nettype wire
